@@ src/assert_macros.svh @@
// Assertion helpers for the RTL.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SBRA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sector allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBRA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sector allocator check failed");

`else

`define SBRA_ASSERT_IMP(label, ante, cons)
`define SBRA_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ src/sbra_pkg.sv @@
`default_nettype none

package sbra_pkg;

  // Default sizes of the map and of one sector's payload.
  localparam int MAP_SECTORS_DEF   = 1024;
  localparam int PAYLOAD_BYTES_DEF = 504;

  // Fixed field widths of the request and result ports.
  localparam int LEN_W   = 24;
  localparam int START_W = 10;
  localparam int FOUND_W = 10;

  // Map word layout: 32 bits per word, scanned one byte at a time.
  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int WORD_BYTES = WORD_W / BYTE_W;
  localparam int OFF_W      = $clog2(WORD_W);
  localparam int BSEL_W     = $clog2(WORD_BYTES);
  localparam int BIT_W      = $clog2(BYTE_W);

  // Depth of the command queue between front and back.
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [FOUND_W-1:0]   found_sector;
    logic                 sector_free;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLR,
    B_IDLE,
    B_SCAN_RD,
    B_SCAN,
    B_RMW_RD,
    B_RMW_WR,
    B_QRY_RD,
    B_QRY_BIT
  } back_state_t;

endpackage

`default_nettype wire

@@ src/sbra_front.sv @@
`default_nettype none

module sbra_front #(
  parameter int MAP_SECTORS   = sbra_pkg::MAP_SECTORS_DEF,
  parameter int PAYLOAD_BYTES = sbra_pkg::PAYLOAD_BYTES_DEF,
  localparam int SEC_W        = $clog2(MAP_SECTORS),
  localparam int ENTRY_W      = 2 * SEC_W + 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        init_done,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [sbra_pkg::START_W-1:0] start_sector,
  input  logic [sbra_pkg::LEN_W-1:0]  byte_length,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output logic [ENTRY_W-1:0]          cmd_data
);
  import sbra_pkg::*;

  // Divider sizing: the sector count never needs more than QW bits.
  localparam int Q_MAX = ((1 << LEN_W) - 1 + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
  localparam int QW    = $clog2(Q_MAX + 1);
  localparam int DV_W  = LEN_W + 1;
  // Reciprocal of the payload size, exact for every DV_W-bit dividend.
  localparam int PL_W  = $clog2(PAYLOAD_BYTES);
  localparam int SH    = DV_W + PL_W;
  localparam int PW    = 2 * DV_W + 1;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(PAYLOAD_BYTES) - 1) /
                             longint'(PAYLOAD_BYTES);
  localparam int CW_A  = (QW > SEC_W + 1) ? QW : SEC_W + 1;
  localparam int EW    = ((CW_A > START_W) ? CW_A : START_W) + 1;

  typedef struct packed {
    act_t               action;
    logic               reject;
    logic [SEC_W-1:0]   start;
    logic [SEC_W:0]     count;
  } cmd_t;

  front_state_t      state, state_next;
  act_t              act_q;
  logic [START_W-1:0] start_q;
  logic [DV_W-1:0]   dv_q;
  logic [QW-1:0]     quo;

  logic [DV_W-1:0]   dividend;
  logic [PW-1:0]     prod;
  logic [QW-1:0]     count_w;
  logic              too_big;
  logic              free_oor;
  logic              query_oor;
  cmd_t              cmd;

  // Rounded-up dividend and its product with the reciprocal.
  assign dividend = DV_W'(byte_length) + DV_W'(PAYLOAD_BYTES - 1);
  assign prod     = PW'(dv_q) * PW'(RECIP);

  // Classify the request once the sector count is known.
  always_comb begin
    count_w   = (quo == '0) ? QW'(1) : quo;
    too_big   = EW'(count_w) > EW'(MAP_SECTORS);
    free_oor  = (EW'(start_q) + EW'(count_w)) > EW'(MAP_SECTORS);
    query_oor = EW'(start_q) >= EW'(MAP_SECTORS);
    cmd.action = act_q;
    cmd.start  = SEC_W'(start_q);
    cmd.count  = (SEC_W + 1)'(count_w);
    case (act_q)
      ACT_ALLOC: cmd.reject = too_big;
      ACT_FREE:  cmd.reject = free_oor;
      ACT_QUERY: cmd.reject = query_oor;
      default:   cmd.reject = 1'b0;
    endcase
  end

  assign cmd_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd_valid  = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = init_done;
        if (in_valid && init_done) begin
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Request capture, then the quotient from the reciprocal product.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_q   <= act_t'(action);
      start_q <= start_sector;
      dv_q    <= dividend;
    end else if (state == F_DIV) begin
      quo <= prod[SH +: QW];
    end
  end

endmodule

`default_nettype wire

@@ src/sbra_queue.sv @@
`default_nettype none

module sbra_queue #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import sbra_pkg::*;

  localparam int PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int FILL_W = $clog2(Q_DEPTH + 1);

  logic [W-1:0]      slots [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push, do_pop;

  assign push_ready = fill != FILL_W'(Q_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/sbra_back.sv @@
`default_nettype none

module sbra_back #(
  parameter int MAP_SECTORS = sbra_pkg::MAP_SECTORS_DEF,
  localparam int SEC_W      = $clog2(MAP_SECTORS),
  localparam int ENTRY_W    = 2 * SEC_W + 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [ENTRY_W-1:0]  cmd_data,
  output logic                res_valid,
  input  logic                res_ready,
  output sbra_pkg::result_t   res,
  output logic                init_done
);
  import sbra_pkg::*;

  localparam int MAP_WORDS = (MAP_SECTORS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = SEC_W - OFF_W;

  typedef struct packed {
    act_t               action;
    logic               reject;
    logic [SEC_W-1:0]   start;
    logic [SEC_W:0]     count;
  } cmd_t;

  // Map storage and its registered read data.
  logic [WORD_W-1:0] mem [MAP_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we, mem_re;
  logic [WA_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  back_state_t       state, state_next;
  logic              init_pass, init_next;
  logic [WA_W-1:0]   word, word_next;
  logic [BSEL_W-1:0] bsel, bsel_next;
  logic [SEC_W:0]    run_len, len_next;
  logic [SEC_W-1:0]  run_start, rs_next;
  logic [SEC_W-1:0]  run_first, first_next;
  logic [SEC_W-1:0]  run_last, last_next;
  logic              mark, mark_next;
  cmd_t              cmd, cmd_next, cmd_in;
  logic              res_load;
  result_t           res_next;

  logic              scan_hit;
  logic [SEC_W:0]    scan_len;
  logic [SEC_W-1:0]  scan_start, scan_sec;
  logic [WORD_W-1:0] rmw_mask;

  assign cmd_in    = cmd_t'(cmd_data);
  assign init_done = !init_pass;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // First-fit scan over one byte of the current word.
  always_comb begin
    logic [BYTE_W-1:0] byte_bits;
    logic [SEC_W-1:0]  base;
    logic [SEC_W-1:0]  s_v;
    logic              used_v;
    byte_bits  = rd_data[bsel * BYTE_W +: BYTE_W];
    base       = {word, bsel, {BIT_W{1'b0}}};
    scan_len   = run_len;
    scan_start = run_start;
    scan_hit   = 1'b0;
    scan_sec   = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      s_v    = base | SEC_W'(i);
      used_v = byte_bits[i] || ({1'b0, s_v} >= (SEC_W + 1)'(MAP_SECTORS));
      if (!scan_hit) begin
        if (used_v) begin
          scan_len = '0;
        end else begin
          if (scan_len == '0) begin
            scan_start = s_v;
          end
          scan_len = scan_len + 1'b1;
          if (scan_len >= cmd.count) begin
            scan_hit = 1'b1;
            scan_sec = s_v;
          end
        end
      end
    end
  end

  // Bits of the current word that fall inside the run.
  always_comb begin
    logic [WORD_W-1:0] lo, hi;
    lo = (word == run_first[SEC_W-1:OFF_W]) ?
         ({WORD_W{1'b1}} << run_first[OFF_W-1:0]) : {WORD_W{1'b1}};
    hi = (word == run_last[SEC_W-1:OFF_W]) ?
         ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - run_last[OFF_W-1:0])) : {WORD_W{1'b1}};
    rmw_mask = lo & hi;
    // Sector 0 stays used when a free covers it.
    if (!mark && word == '0) begin
      rmw_mask[0] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      init_pass <= 1'b1;
      word      <= '0;
    end else begin
      state     <= state_next;
      init_pass <= init_next;
      word      <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    bsel      <= bsel_next;
    run_len   <= len_next;
    run_start <= rs_next;
    run_first <= first_next;
    run_last  <= last_next;
    mark      <= mark_next;
    cmd       <= cmd_next;
  end

  // Result slot: holds one finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // Sequencer for clear sweeps, scans, read-modify-write passes and queries.
  always_comb begin
    state_next = state;
    init_next  = init_pass;
    word_next  = word;
    bsel_next  = bsel;
    len_next   = run_len;
    rs_next    = run_start;
    first_next = run_first;
    last_next  = run_last;
    mark_next  = mark;
    cmd_next   = cmd;
    mem_we     = 1'b0;
    mem_waddr  = word;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = word;
    cmd_ready  = 1'b0;
    res_load   = 1'b0;
    res_next   = '{status: ST_OK, found_sector: '0, sector_free: 1'b0};
    unique case (state)
      B_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = (word == '0) ? WORD_W'(1) : '0;
        if (word == WA_W'(MAP_WORDS - 1)) begin
          word_next  = '0;
          state_next = B_IDLE;
          init_next  = 1'b0;
          res_load   = !init_pass;
        end else begin
          word_next = word + 1'b1;
        end
      end
      B_IDLE: begin
        cmd_ready = !res_valid;
        if (cmd_valid && !res_valid) begin
          cmd_next = cmd_in;
          unique case (cmd_in.action)
            ACT_ALLOC: begin
              mark_next = 1'b1;
              if (cmd_in.reject) begin
                res_load        = 1'b1;
                res_next.status = ST_NO_SPACE;
              end else begin
                state_next = B_SCAN_RD;
              end
            end
            ACT_FREE: begin
              mark_next  = 1'b0;
              first_next = cmd_in.start;
              last_next  = SEC_W'({1'b0, cmd_in.start} + cmd_in.count - 1'b1);
              word_next  = cmd_in.start[SEC_W-1:OFF_W];
              if (cmd_in.reject) begin
                res_load        = 1'b1;
                res_next.status = ST_RANGE;
              end else begin
                state_next = B_RMW_RD;
              end
            end
            ACT_QUERY: begin
              if (cmd_in.reject) begin
                res_load        = 1'b1;
                res_next.status = ST_RANGE;
              end else begin
                state_next = B_QRY_RD;
              end
            end
            ACT_CLEAR: begin
              word_next  = '0;
              state_next = B_CLR;
            end
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_SCAN_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = '0;
        word_next  = '0;
        bsel_next  = '0;
        len_next   = '0;
        state_next = B_SCAN;
      end
      B_SCAN: begin
        if (scan_hit) begin
          first_next = scan_start;
          last_next  = scan_sec;
          word_next  = scan_start[SEC_W-1:OFF_W];
          state_next = B_RMW_RD;
        end else begin
          len_next = scan_len;
          rs_next  = scan_start;
          if (bsel == BSEL_W'(WORD_BYTES - 1)) begin
            if (word == WA_W'(MAP_WORDS - 1)) begin
              res_load        = 1'b1;
              res_next.status = ST_NO_SPACE;
              state_next      = B_IDLE;
            end else begin
              word_next = word + 1'b1;
              mem_re    = 1'b1;
              mem_raddr = word + 1'b1;
              bsel_next = '0;
            end
          end else begin
            bsel_next = bsel + 1'b1;
          end
        end
      end
      B_RMW_RD: begin
        mem_re     = 1'b1;
        state_next = B_RMW_WR;
      end
      B_RMW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mark ? (rd_data | rmw_mask) : (rd_data & ~rmw_mask);
        if (word == run_last[SEC_W-1:OFF_W]) begin
          res_load              = 1'b1;
          res_next.found_sector = mark ? FOUND_W'(run_first) : '0;
          state_next            = B_IDLE;
        end else begin
          word_next  = word + 1'b1;
          state_next = B_RMW_RD;
        end
      end
      B_QRY_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = cmd.start[SEC_W-1:OFF_W];
        state_next = B_QRY_BIT;
      end
      B_QRY_BIT: begin
        res_load             = 1'b1;
        res_next.sector_free = !rd_data[cmd.start[OFF_W-1:0]];
        state_next           = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/sector_bitmap_run_allocator_top.sv @@
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   action, start_sector, byte_length
// result    out        out_valid / out_ready status, found_sector, sector_free
//
// The front takes a request, turns byte_length into a sector count with one
// constant reciprocal multiply in the next cycle, and offers the command to a
// two-entry queue in the cycle after.
// The back scans the map one byte a cycle from a word memory with one read and
// one write port: an allocate reads and scans each word, then reads and rewrites
// each marked word; a free reads and rewrites each touched word, a query reads
// one word and tests one bit, and a clear rewrites every map word. After reset
// the back writes the map clean, one word a cycle, and no request is taken until
// that sweep ends. A stalled result holds in the back's result slot; the front
// keeps taking requests until the queue is full.
`default_nettype none
`include "assert_macros.svh"

module sector_bitmap_run_allocator_top #(
  parameter int MAP_SECTORS   = sbra_pkg::MAP_SECTORS_DEF,
  parameter int PAYLOAD_BYTES = sbra_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   action,
  input  logic [sbra_pkg::START_W-1:0] start_sector,
  input  logic [sbra_pkg::LEN_W-1:0]   byte_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [sbra_pkg::FOUND_W-1:0] found_sector,
  output logic                         sector_free
);
  import sbra_pkg::*;

  localparam int SEC_W   = $clog2(MAP_SECTORS);
  localparam int ENTRY_W = 2 * SEC_W + 4;

  logic               init_done;
  logic               f_valid, f_ready;
  logic [ENTRY_W-1:0] f_data;
  logic               q_valid, q_ready;
  logic [ENTRY_W-1:0] q_data;
  result_t            res;

  // Request intake and sector count.
  sbra_front #(
    .MAP_SECTORS   (MAP_SECTORS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .init_done    (init_done),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .start_sector (start_sector),
    .byte_length  (byte_length),
    .cmd_valid    (f_valid),
    .cmd_ready    (f_ready),
    .cmd_data     (f_data)
  );

  // Command queue between the two halves.
  sbra_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Map engine.
  sbra_back #(
    .MAP_SECTORS (MAP_SECTORS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_data),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res),
    .init_done (init_done)
  );

  assign status       = res.status;
  assign found_sector = res.found_sector;
  assign sector_free  = res.sector_free;

  // No request is taken while the reset sweep still runs.
  `SBRA_ASSERT_IMP(a_ready_after_init, in_ready, init_done)
  // The front is busy dividing in the cycle after it takes a request.
  `SBRA_ASSERT_NXT(a_front_busy, in_valid && in_ready, !in_ready)
  // The back only starts a command while its result slot is empty.
  `SBRA_ASSERT_IMP(a_pop_slot_free, q_valid && q_ready, !out_valid)
  // The reset sweep never produces a result.
  `SBRA_ASSERT_IMP(a_no_init_result, !init_done, !out_valid)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import sbra_pkg::*;

  localparam int SECTORS = MAP_SECTORS_DEF;
  localparam int PAYLOAD = PAYLOAD_BYTES_DEF;
  localparam int MAX_GAP = 17;

  // One allocated run, kept so that later frees and queries can hit it.
  typedef struct {
    logic [START_W-1:0] run_first;
    logic [LEN_W-1:0]   run_bytes;
  } owned_run_t;

  // Mirror of the sector map and the results still owed by the block.
  class alloc_scoreboard;
    bit [SECTORS-1:0] used_bits;
    result_t          owed_q[$];
    int               errors;

    function new();
      format_map();
      errors = 0;
    endfunction

    function void format_map();
      used_bits = '0;
      used_bits[0] = 1'b1;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Applies one accepted request to the mirror and holds its result.
    function result_t note_request(act_t act, logic [START_W-1:0] first,
                                   logic [LEN_W-1:0] nbytes);
      result_t r;
      int count;
      int run_start;
      int run_len;
      bit in_run;
      bit ok;
      r.status = ST_OK;
      r.found_sector = '0;
      r.sector_free = 1'b0;
      count = (int'(nbytes) + PAYLOAD - 1) / PAYLOAD;
      if (count == 0) count = 1;
      run_start = 0;
      run_len = 0;
      in_run = 1'b0;
      ok = 1'b0;
      case (act)
        ACT_ALLOC: begin
          // First fit: any used sector ends the candidate run.
          for (int i = 0; i < SECTORS; i++) begin
            if (used_bits[i]) begin
              in_run = 1'b0;
              run_len = 0;
            end else begin
              if (!in_run) begin
                in_run = 1'b1;
                run_start = i;
              end
              run_len++;
              if (run_len >= count) begin
                ok = 1'b1;
                break;
              end
            end
          end
          if (ok) begin
            for (int i = 0; i < count; i++) used_bits[run_start + i] = 1'b1;
            r.found_sector = run_start[FOUND_W-1:0];
          end else begin
            r.status = ST_NO_SPACE;
          end
        end
        ACT_FREE: begin
          // A run past the map end is rejected; sector 0 never gets freed.
          if (int'(first) + count > SECTORS) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = 0; i < count; i++)
              if (int'(first) + i != 0) used_bits[int'(first) + i] = 1'b0;
          end
        end
        ACT_QUERY: begin
          if (int'(first) >= SECTORS) r.status = ST_RANGE;
          else r.sector_free = ~used_bits[first];
        end
        default: begin
          format_map();
        end
      endcase
      owed_q.push_back(r);
      return r;
    endfunction

    // Compares one result from the block with the oldest owed result.
    function void check_result(logic [1:0] st, logic [FOUND_W-1:0] found, logic is_free);
      result_t exp_r;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing owed: status %0d found %0d free %0d",
                 $time, st, found, is_free);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (st !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, st);
        errors++;
      end
      if (found !== exp_r.found_sector) begin
        $display("%0t: found_sector expected %0d actual %0d",
                 $time, exp_r.found_sector, found);
        errors++;
      end
      if (is_free !== exp_r.sector_free) begin
        $display("%0t: sector_free expected %0d actual %0d",
                 $time, exp_r.sector_free, is_free);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          action;
  logic [START_W-1:0]  start_sector;
  logic [LEN_W-1:0]    byte_length;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          status;
  logic [FOUND_W-1:0]  found_sector;
  logic                sector_free;

  alloc_scoreboard sb;
  owned_run_t      owned_q[$];
  bit              tx_calm;
  bit              rx_calm;

  sector_bitmap_run_allocator_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .start_sector (start_sector),
    .byte_length  (byte_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_sector (found_sector),
    .sector_free  (sector_free)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sends one request, starting and ending at a falling edge.
  task automatic send_request(act_t act, logic [START_W-1:0] first, logic [LEN_W-1:0] nbytes);
    int gap;
    result_t r;
    owned_run_t run;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    start_sector <= first;
    byte_length  <= nbytes;
    do @(posedge clk); while (!in_ready);
    r = sb.note_request(act, first, nbytes);
    // Track live runs for well-formed frees later on.
    if (act == ACT_ALLOC && r.status == ST_OK) begin
      run.run_first = r.found_sector;
      run.run_bytes = nbytes;
      owned_q.push_back(run);
    end
    if (act == ACT_CLEAR) owned_q.delete();
    @(negedge clk);
  endtask

  // Length in bytes that needs exactly the given number of sectors.
  function automatic logic [LEN_W-1:0] bytes_for(int count);
    return LEN_W'(count * PAYLOAD - $urandom_range(0, PAYLOAD - 1));
  endfunction

  // One random request, weighted toward sequences that fill and fragment the map.
  task automatic send_random_request();
    int pick;
    int idx;
    int sel;
    logic [LEN_W-1:0] nbytes;
    owned_run_t run;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) nbytes = LEN_W'($urandom_range(0, 16 * PAYLOAD));
      else if (sel < 82) nbytes = LEN_W'($urandom_range(0, 200 * PAYLOAD));
      else if (sel < 92) nbytes = LEN_W'($urandom());
      else nbytes = LEN_W'($urandom_range(1, 40) * PAYLOAD + $urandom_range(0, 1));
      send_request(ACT_ALLOC, START_W'($urandom()), nbytes);
    end else if (pick < 65 && owned_q.size() > 0) begin
      idx = $urandom_range(0, owned_q.size() - 1);
      run = owned_q[idx];
      owned_q.delete(idx);
      send_request(ACT_FREE, run.run_first, run.run_bytes);
    end else if (pick < 75 || pick < 65) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) nbytes = LEN_W'($urandom());
      else nbytes = bytes_for($urandom_range(1, 24));
      send_request(ACT_FREE, START_W'($urandom()), nbytes);
    end else if (pick < 98) begin
      if (owned_q.size() > 0 && $urandom_range(0, 1) == 1) begin
        run = owned_q[$urandom_range(0, owned_q.size() - 1)];
        send_request(ACT_QUERY, START_W'(run.run_first + $urandom_range(0, 3)),
                     LEN_W'($urandom()));
      end else begin
        send_request(ACT_QUERY, START_W'($urandom()), LEN_W'($urandom()));
      end
    end else begin
      send_request(ACT_CLEAR, START_W'($urandom()), LEN_W'($urandom()));
    end
  endtask

  // Result side: random stalls, each result checked at the accepting edge.
  initial begin
    int gap;
    int seen;
    seen = 0;
    rx_calm = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(status, found_sector, sector_free);
      seen++;
      @(negedge clk);
    end
  end

  // Request side: reset, directed cases, random traffic, then drain.
  initial begin
    int waited;
    sb = new();
    tx_calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_ALLOC;
    start_sector = '0;
    byte_length = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sector 0 is used from reset, the last sector is free.
    send_request(ACT_QUERY, 10'd0, 24'd0);
    send_request(ACT_QUERY, 10'd1023, 24'hFFFFFF);
    // Zero length still takes one sector; length boundaries around one sector.
    send_request(ACT_ALLOC, 10'd0, 24'd0);
    send_request(ACT_ALLOC, 10'd0, 24'd1);
    send_request(ACT_ALLOC, 10'd0, 24'(PAYLOAD));
    send_request(ACT_ALLOC, 10'd0, 24'(PAYLOAD + 1));
    send_request(ACT_ALLOC, 10'd0, 24'hFFFFFF);
    // A one-sector hole must be skipped by a two-sector request.
    send_request(ACT_FREE, 10'd3, 24'd0);
    send_request(ACT_ALLOC, 10'd0, 24'(2 * PAYLOAD));
    send_request(ACT_ALLOC, 10'd0, 24'd1);
    send_request(ACT_QUERY, 10'd3, 24'd0);
    send_request(ACT_QUERY, 10'd8, 24'd0);
    // A free over sector 0 leaves it used.
    send_request(ACT_FREE, 10'd0, 24'(4 * PAYLOAD));
    send_request(ACT_QUERY, 10'd0, 24'd0);
    send_request(ACT_QUERY, 10'd1, 24'd0);
    // Runs past the map end are rejected; one ending on the last sector is fine.
    send_request(ACT_FREE, 10'd1023, 24'(PAYLOAD + 1));
    send_request(ACT_FREE, 10'd1023, 24'(PAYLOAD));
    send_request(ACT_FREE, 10'd0, 24'hFFFFFF);
    // Fill the whole map in one run, then nothing fits.
    send_request(ACT_CLEAR, 10'h3FF, 24'hFFFFFF);
    send_request(ACT_ALLOC, 10'd0, 24'((SECTORS - 1) * PAYLOAD));
    send_request(ACT_ALLOC, 10'd0, 24'd0);
    send_request(ACT_QUERY, 10'd1023, 24'd0);
    send_request(ACT_FREE, 10'd1, 24'((SECTORS - 1) * PAYLOAD));
    send_request(ACT_ALLOC, 10'd0, 24'(SECTORS * PAYLOAD));
    send_request(ACT_CLEAR, 10'd0, 24'd0);

    for (int n = 0; n < 500; n++) begin
      if (n % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    in_valid <= 1'b0;

    // Drain the owed results, then give the block time to show any extra one.
    waited = 0;
    while (sb.pending() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/sbra_pkg.sv
src/sbra_front.sv
src/sbra_queue.sv
src/sbra_back.sv
src/sector_bitmap_run_allocator_top.sv
tb/tb.sv
